[src/debounced_sequence_lock_unit_assert.svh]
// ----------------------------------------------------------------------------
// Debounced sequence lock assertion macros
// Shared property wrappers for the checker, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_SEQUENCE_LOCK_UNIT_ASSERT_SVH
`define DEBOUNCED_SEQUENCE_LOCK_UNIT_ASSERT_SVH

// same-cycle implication
`define DSL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dsl assertion failed");

// next-cycle implication
`define DSL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dsl assertion failed");

`endif

[src/dsl_pkg.sv]
// ----------------------------------------------------------------------------
// Debounced sequence lock package
// Sizes, register indexes and code helpers shared by the lock and its checker.
// ----------------------------------------------------------------------------
package dsl_pkg;

  localparam int NUM_DETECTORS  = 5;
  localparam int LOG_DEPTH      = 4;
  localparam int DEBOUNCE_LIMIT = 5;

  localparam int IDX_W   = 3;
  localparam int CODE_W  = 12;
  localparam int SENSE_W = 5;
  localparam int CNT_W   = $clog2(DEBOUNCE_LIMIT + 1);
  localparam int CFG_W   = CODE_W;
  localparam int CFGA_W  = 1;

  localparam logic [IDX_W-1:0]  NONE_ENTRY   = '1;
  localparam logic [CNT_W-1:0]  CNT_LIMIT    = CNT_W'(DEBOUNCE_LIMIT);
  localparam logic [CODE_W-1:0] CODE_RESET   = '1;

  typedef enum logic [CFGA_W-1:0] {
    REG_TRIP_POLARITY = 1'b0,
    REG_UNLOCK_CODE   = 1'b1
  } cfg_reg_e;

  typedef logic [IDX_W-1:0] entry_t;

  // entry i of the packed code, none beyond the register width
  function automatic entry_t code_entry(input logic [CODE_W-1:0] code, input int i);
    entry_t e;
    e = NONE_ENTRY;
    if (IDX_W * i + IDX_W <= CODE_W) begin
      e = code[IDX_W*i +: IDX_W];
    end
    return e;
  endfunction

endpackage

[src/debounced_sequence_lock_unit.sv]
// ----------------------------------------------------------------------------
// Debounced sequence lock unit
// Integrating debounce of five detectors feeding an ordered unlock log.
// ----------------------------------------------------------------------------
// Each input transaction is one debounce tick and yields exactly one result
// transaction. The block takes one tick per clock cycle: all debounce,
// pick and log work sits between the state registers and the result
// register, and a new tick is accepted while the previous result is taken.
// A stalled result holds off input only while out_ready_i stays low.
// Configuration writes take effect at once and belong in idle periods.
module debounced_sequence_lock_unit
  import dsl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFGA_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [SENSE_W-1:0]       sensor_levels_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SENSE_W-1:0]       tripped_mask_o,
  output logic                     log_updated_o,
  output logic [CODE_W-1:0]        history_log_o,
  output logic                     code_matches_o
);

  logic                trip_polarity_q;
  logic [CODE_W-1:0]   unlock_code_q;
  logic [CNT_W-1:0]    cnt_q [NUM_DETECTORS];
  logic [CNT_W-1:0]    cnt_d [NUM_DETECTORS];
  logic [NUM_DETECTORS-1:0] trip_q, trip_d;
  entry_t              log_q [LOG_DEPTH];
  entry_t              log_d [LOG_DEPTH];
  logic                out_valid_q;
  logic                log_updated_q, log_updated_d;
  logic                match_q, match_d;
  logic                accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [NUM_DETECTORS-1:0] qual;
    logic                     new_trip;
    logic [IDX_W:0]           n_trip;
    logic                     level;
    logic                     found;
    entry_t                   pick;
    qual     = '0;
    new_trip = 1'b0;
    n_trip   = '0;
    found    = 1'b0;
    pick     = NONE_ENTRY;
    trip_d   = trip_q;
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      cnt_d[d] = cnt_q[d];
      for (int j = 0; j < LOG_DEPTH; j++) begin
        if (code_entry(unlock_code_q, j) == IDX_W'(d)) begin
          qual[d] = 1'b1;
        end
      end
      level = (d < SENSE_W) ? sensor_levels_i[d] : 1'b0;
      if (qual[d]) begin
        if (level == trip_polarity_q) begin
          if (cnt_q[d] < CNT_LIMIT) begin
            cnt_d[d] = cnt_q[d] + CNT_W'(1);
          end
        end else if (cnt_q[d] != '0) begin
          cnt_d[d] = cnt_q[d] - CNT_W'(1);
        end
        if (cnt_d[d] == CNT_LIMIT) begin
          new_trip  = new_trip || !trip_q[d];
          trip_d[d] = 1'b1;
        end else if (cnt_d[d] == '0) begin
          trip_d[d] = 1'b0;
        end
        n_trip = n_trip + (IDX_W+1)'(trip_d[d]);
      end
    end
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      if (trip_d[d] && !found) begin
        found = 1'b1;
        pick  = IDX_W'(d);
      end
    end
    log_updated_d = new_trip && (n_trip == (IDX_W+1)'(1));
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_d[i] = log_q[i];
    end
    if (log_updated_d) begin
      for (int i = 0; i + 1 < LOG_DEPTH; i++) begin
        log_d[i] = log_q[i+1];
      end
      log_d[LOG_DEPTH-1] = pick;
    end
    match_d = 1'b1;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      if (log_d[i] != code_entry(unlock_code_q, i)) begin
        match_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_polarity_q <= 1'b0;
      unlock_code_q   <= CODE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TRIP_POLARITY: trip_polarity_q <= cfg_data_i[0];
        REG_UNLOCK_CODE:   unlock_code_q   <= cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_q      <= '0;
      out_valid_q <= 1'b0;
      for (int d = 0; d < NUM_DETECTORS; d++) begin
        cnt_q[d] <= '0;
      end
      for (int i = 0; i < LOG_DEPTH; i++) begin
        log_q[i] <= NONE_ENTRY;
      end
    end else begin
      if (accept) begin
        trip_q <= trip_d;
        for (int d = 0; d < NUM_DETECTORS; d++) begin
          cnt_q[d] <= cnt_d[d];
        end
        for (int i = 0; i < LOG_DEPTH; i++) begin
          log_q[i] <= log_d[i];
        end
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      log_updated_q <= log_updated_d;
      match_q       <= match_d;
    end
  end

  always_comb begin
    history_log_o  = '0;
    tripped_mask_o = '0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      if (IDX_W * i + IDX_W <= CODE_W) begin
        history_log_o[IDX_W*i +: IDX_W] = log_q[i];
      end
    end
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      if (d < SENSE_W) begin
        tripped_mask_o[d] = trip_q[d];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign log_updated_o  = log_updated_q;
  assign code_matches_o = match_q;

endmodule

[src/dsl_checker.sv]
// ----------------------------------------------------------------------------
// Debounced sequence lock checker
// Port-level properties of the lock unit, bound into the lock unit module.
// ----------------------------------------------------------------------------
`include "debounced_sequence_lock_unit_assert.svh"

module dsl_checker
  import dsl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CFGA_W-1:0]   cfg_index_i,
  input logic [CFG_W-1:0]    cfg_data_i,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [SENSE_W-1:0]  sensor_levels_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [SENSE_W-1:0]  tripped_mask_o,
  input logic                log_updated_o,
  input logic [CODE_W-1:0]   history_log_o,
  input logic                code_matches_o
);

  logic in_xfer;
  logic unused_cfg;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign unused_cfg = cfg_we_i ^ (|cfg_index_i) ^ (|cfg_data_i) ^ (|sensor_levels_i)
                      ^ code_matches_o;

  `DSL_ASSERT_NXT(a_result_after_tick, in_xfer, out_valid_o)
  `DSL_ASSERT_IMP(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o)
  `DSL_ASSERT_IMP(a_log_needs_trip, out_valid_o && log_updated_o, tripped_mask_o != '0)
  `DSL_ASSERT_NXT(a_stalled_result_holds, out_valid_o && !out_ready_i,
                  $stable(history_log_o) && $stable(tripped_mask_o))

endmodule

bind debounced_sequence_lock_unit dsl_checker u_dsl_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounced sequence lock unit testbench
// Drives debounce ticks through the valid/ready input with bursty timing,
// stalls the result side on a random pattern, and checks every result
// transaction against an in-bench model of the counters, flags and log.
// ----------------------------------------------------------------------------
module tb;
  import dsl_pkg::*;

  typedef struct packed {
    logic [SENSE_W-1:0] tripped_mask;
    logic               log_updated;
    logic [CODE_W-1:0]  history_log;
    logic               code_matches;
  } lock_result_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CFGA_W-1:0]  cfg_index_i     = '0;
  logic [CFG_W-1:0]   cfg_data_i      = '0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [SENSE_W-1:0] sensor_levels_i = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [SENSE_W-1:0] tripped_mask_o;
  logic               log_updated_o;
  logic [CODE_W-1:0]  history_log_o;
  logic               code_matches_o;

  debounced_sequence_lock_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sensor_levels_i(sensor_levels_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .tripped_mask_o (tripped_mask_o),
    .log_updated_o  (log_updated_o),
    .history_log_o  (history_log_o),
    .code_matches_o (code_matches_o)
  );

  always #10 clk_i = ~clk_i;

  // lock model state
  logic              lock_polarity;
  logic [CODE_W-1:0] lock_code;
  logic [CNT_W-1:0]  det_count   [NUM_DETECTORS];
  logic              det_tripped [NUM_DETECTORS];
  entry_t            log_slots   [LOG_DEPTH];

  lock_result_t predicted_results[$];
  lock_result_t observed;
  lock_result_t wanted;
  int           mismatches = 0;
  int           burst_left = 1;

  logic [31:0]  stall_pattern = '1;
  logic [5:0]   stall_slot    = '0;
  logic         stall_free    = 1'b1;

  function automatic logic det_armed(input int det);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      if (lock_code[IDX_W*i +: IDX_W] == det) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic predict_tick(input logic [SENSE_W-1:0] levels, output lock_result_t res);
    logic              fresh;
    int                n_tripped;
    entry_t            pick;
    logic [CODE_W-1:0] packed_log;
    fresh     = 1'b0;
    n_tripped = 0;
    pick      = NONE_ENTRY;
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      if (det_armed(d)) begin
        if (levels[d] == lock_polarity) begin
          if (det_count[d] < CNT_LIMIT) begin
            det_count[d]++;
          end
        end else if (det_count[d] != '0) begin
          det_count[d]--;
        end
        if (det_count[d] == CNT_LIMIT) begin
          if (!det_tripped[d]) begin
            fresh = 1'b1;
          end
          det_tripped[d] = 1'b1;
        end else if (det_count[d] == '0) begin
          det_tripped[d] = 1'b0;
        end
        if (det_tripped[d]) begin
          n_tripped++;
        end
      end
    end
    res.log_updated = fresh && (n_tripped == 1);
    if (res.log_updated) begin
      // stale flags of unqualified detectors still win the lowest-index pick
      for (int d = NUM_DETECTORS - 1; d >= 0; d--) begin
        if (det_tripped[d]) begin
          pick = entry_t'(d);
        end
      end
      for (int i = 0; i < LOG_DEPTH - 1; i++) begin
        log_slots[i] = log_slots[i+1];
      end
      log_slots[LOG_DEPTH-1] = pick;
    end
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      res.tripped_mask[d] = det_tripped[d];
    end
    packed_log = '0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      packed_log[IDX_W*i +: IDX_W] = log_slots[i];
    end
    res.history_log  = packed_log;
    res.code_matches = (packed_log == lock_code);
  endtask

  task automatic send_tick(input logic [SENSE_W-1:0] levels);
    lock_result_t res;
    int           gap;
    in_valid_i      <= 1'b1;
    sensor_levels_i <= levels;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_tick(levels, res);
    predicted_results.push_back(res);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold an active pattern, translated to raw levels by the polarity
  task automatic send_active(input logic [SENSE_W-1:0] active, input int ticks);
    repeat (ticks) send_tick(lock_polarity ? active : ~active);
  endtask

  task automatic drain_results;
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      REG_TRIP_POLARITY: lock_polarity = value[0];
      REG_UNLOCK_CODE:   lock_code     = value[CODE_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed = {tripped_mask_o, log_updated_o, history_log_o, code_matches_o};
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: mask=%b upd=%b log=%o match=%b",
                   observed.tripped_mask, observed.log_updated,
                   observed.history_log, observed.code_matches);
        end
      end else begin
        wanted = predicted_results.pop_front();
        if (observed.tripped_mask !== wanted.tripped_mask ||
            observed.log_updated  !== wanted.log_updated  ||
            observed.history_log  !== wanted.history_log  ||
            observed.code_matches !== wanted.code_matches) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected mask=%b upd=%b log=%o match=%b",
                     wanted.tripped_mask, wanted.log_updated,
                     wanted.history_log, wanted.code_matches);
            $display("          got      mask=%b upd=%b log=%o match=%b",
                     observed.tripped_mask, observed.log_updated,
                     observed.history_log, observed.code_matches);
          end
        end
      end
    end
  end

  // result-side stall pattern, with stall-free stretches
  always @(posedge clk_i) begin
    if (stall_slot == '0) begin
      stall_pattern <= $urandom | $urandom;
      stall_free    <= ($urandom_range(0, 3) == 0);
    end
    stall_slot  <= stall_slot + 1'b1;
    out_ready_i <= stall_free || stall_pattern[stall_slot[4:0]];
  end

  // reset code qualifies nothing; an all-none log matches the all-ones code
  task automatic test_unqualified_idle;
    send_tick('0);
    send_tick('1);
    send_tick(5'b10101);
    drain_results();
  endtask

  // a flag left set after a code change still wins the pick but is not counted
  task automatic test_frozen_flag_pick;
    write_reg(REG_TRIP_POLARITY, CFG_W'(1));
    write_reg(REG_UNLOCK_CODE, '0);
    send_active('1, 5);
    drain_results();
    write_reg(REG_UNLOCK_CODE, 12'o1111);
    send_active(5'b00010, 5);
    drain_results();
  endtask

  // code entries 5 to 7 qualify nothing; low polarity trips on level 0
  task automatic test_high_code_entries;
    write_reg(REG_TRIP_POLARITY, CFG_W'(0));
    write_reg(REG_UNLOCK_CODE, 12'o4765);
    send_active(5'b10000, 5);
    send_active('0, 1);
    drain_results();
  endtask

  task automatic test_random_sequences;
    int unsigned       sent;
    int unsigned       mode;
    int unsigned       ticks;
    logic [CODE_W-1:0] code;
    entry_t            e;
    for (int phase = 0; phase < 20; phase++) begin
      write_reg(REG_TRIP_POLARITY,
                CFG_W'((phase < 4) ? phase[0] : $urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0: code = (phase[1]) ? '0 : '1;
        1: code = CODE_W'($urandom);
        default: begin
          for (int i = 0; i < LOG_DEPTH; i++) begin
            code[IDX_W*i +: IDX_W] = IDX_W'($urandom_range(0, NUM_DETECTORS - 1));
          end
        end
      endcase
      write_reg(REG_UNLOCK_CODE, code);
      sent = 0;
      while (sent < 80) begin
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
          // walk the code: trip each entry alone, then release
          for (int i = 0; i < LOG_DEPTH; i++) begin
            e = lock_code[IDX_W*i +: IDX_W];
            ticks = $urandom_range(5, 7);
            send_active((e < NUM_DETECTORS) ? SENSE_W'(1) << e : '0, ticks);
            sent += ticks;
            ticks = $urandom_range(5, 7);
            send_active('0, ticks);
            sent += ticks;
          end
        end else if (mode < 8) begin
          ticks = $urandom_range(1, 8);
          send_active(($urandom_range(0, 2) != 0) ? SENSE_W'(1) << $urandom_range(0, 4)
                                                  : SENSE_W'($urandom), ticks);
          sent += ticks;
        end else begin
          ticks = $urandom_range(1, 4);
          repeat (ticks) send_tick(SENSE_W'($urandom));
          sent += ticks;
        end
      end
      drain_results();
    end
  endtask

  initial begin
    lock_polarity = 1'b0;
    lock_code     = CODE_RESET;
    for (int d = 0; d < NUM_DETECTORS; d++) begin
      det_count[d]   = '0;
      det_tripped[d] = 1'b0;
    end
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_slots[i] = NONE_ENTRY;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unqualified_idle();
    test_frozen_flag_pick();
    test_high_code_entries();
    test_random_sequences();
    drain_results();
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/dsl_pkg.sv
src/debounced_sequence_lock_unit.sv
src/dsl_checker.sv
sim/tb.sv
